// ===== design/bb3ea_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3ea_pkg
// Shared constants, codes and control types of the edge-aware 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3ea_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_FRAME_SIZE = 1024;

   localparam int PIX_W     = 24;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 3;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W     = 12;   // nine 8-bit samples
   localparam int CNT_W     = 4;    // up to nine neighbours
   localparam int NUM_W     = 13;   // 2*sum + count
   localparam int DEN_W     = 5;    // 2*count
   localparam int STEP_W    = 4;
   localparam int RD_STEPS  = 3;    // one column of three rows per step
   localparam int DIV_STEPS = NUM_W;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic       latch_item;
      logic       cfg_write;
      logic       write_pixel;
      logic       rd_issue;
      logic [1:0] rd_col;
      logic       acc_clear;
      logic       acc_en;
      logic       div_start;
      logic       div_step;
      logic       load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic item_drain;
      logic full;
      logic out_ready;
      logic rsp_free;
   } status_type;

   // clamp a size register: zero reads as one, above the maximum as the maximum
   function automatic int clamp_size(logic [CFG_W-1:0] v, int max_v);
      int r;
      r = int'(v);
      if (r < 1) r = 1;
      if (r > max_v) r = max_v;
      return r;
   endfunction

endpackage

// ===== design/bb3ea_if.sv =====
// ----------------------------------------------------------------------------
// bb3ea_if
// Valid/ready channels of the box blur: pixel requests, results, register writes.
// ----------------------------------------------------------------------------
interface bb3ea_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [bb3ea_pkg::PIX_W-1:0] pixel;
   modport source (output valid, output opcode, output pixel, input ready);
   modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

interface bb3ea_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bb3ea_pkg::PIX_W-1:0] blurred_pixel;
   logic                       frame_end;
   modport source (output valid, output blurred_pixel, output frame_end, input ready);
   modport sink   (input valid, input blurred_pixel, input frame_end, output ready);
endinterface

interface bb3ea_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bb3ea_pkg::CSR_IDX_W-1:0] reg_index;
   logic [bb3ea_pkg::CFG_W-1:0]     wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/bb3ea_ram.sv =====
// ----------------------------------------------------------------------------
// bb3ea_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bb3ea_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/bb3ea_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3ea_ctrl
// Sequencer: decides per item whether to emit, write, or drop, and steps the
// datapath through the neighbourhood read and the divider.
// ----------------------------------------------------------------------------
module bb3ea_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  bb3ea_pkg::status_type status,
   output bb3ea_pkg::cmd_type    cmd
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECIDE = 7'b0000010,
      S_READ   = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_EMIT   = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_CHECK  = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [bb3ea_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                           write_after_ff, write_after_in;
   logic                           emitted_ff, emitted_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      write_after_in = write_after_ff;
      emitted_in     = emitted_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      csr_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DECIDE;
            end
         end
         S_DECIDE: begin
            step_in = '0;
            if (status.item_drain) begin
               write_after_in = 1'b0;
               state_in       = status.out_ready ? S_READ : S_IDLE;
            end else if (status.full) begin
               state_in = S_IDLE;
            end else if (status.out_ready) begin
               write_after_in = 1'b1;
               emitted_in     = 1'b1;
               state_in       = S_READ;
            end else begin
               emitted_in = 1'b0;
               state_in   = S_WRITE;
            end
         end
         S_READ: begin
            cmd.rd_col    = step_ff[1:0];
            cmd.rd_issue  = (step_ff < bb3ea_pkg::STEP_W'(bb3ea_pkg::RD_STEPS));
            cmd.acc_clear = (step_ff == '0);
            cmd.acc_en    = (step_ff != '0);
            step_in       = step_ff + 1'b1;
            if (step_ff == bb3ea_pkg::STEP_W'(bb3ea_pkg::RD_STEPS)) begin
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = (step_ff == '0);
            cmd.div_step  = (step_ff != '0);
            step_in       = step_ff + 1'b1;
            if (step_ff == bb3ea_pkg::STEP_W'(bb3ea_pkg::DIV_STEPS)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_out = 1'b1;
               state_in     = write_after_ff ? S_WRITE : S_IDLE;
            end
         end
         S_WRITE: begin
            cmd.write_pixel = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            step_in = '0;
            if (!emitted_ff && status.out_ready) begin
               write_after_in = 1'b0;
               emitted_in     = 1'b1;
               state_in       = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         step_ff        <= '0;
         write_after_ff <= 1'b0;
         emitted_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         write_after_ff <= write_after_in;
         emitted_ff     <= emitted_in;
      end
   end
endmodule

// ===== design/bb3ea_datapath.sv =====
// ----------------------------------------------------------------------------
// bb3ea_datapath
// Frame counters, three row RAMs, neighbourhood accumulator, bit-serial
// rounding divider and the result register.
// ----------------------------------------------------------------------------
module bb3ea_datapath #(
   parameter int MAX_WIDTH  = bb3ea_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3ea_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bb3ea_pkg::cmd_type                cmd,
   output bb3ea_pkg::status_type             status,
   input  logic                              req_opcode,
   input  logic [bb3ea_pkg::PIX_W-1:0]       req_pixel,
   input  logic [bb3ea_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bb3ea_pkg::CFG_W-1:0]       csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bb3ea_pkg::PIX_W-1:0]       rsp_pixel,
   output logic                              rsp_frame_end
);
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int FW_RST = (bb3ea_pkg::DEF_FRAME_SIZE > MAX_WIDTH) ?
                           MAX_WIDTH : bb3ea_pkg::DEF_FRAME_SIZE;
   localparam int FH_RST = (bb3ea_pkg::DEF_FRAME_SIZE > MAX_HEIGHT) ?
                           MAX_HEIGHT : bb3ea_pkg::DEF_FRAME_SIZE;
   localparam int PIX_W  = bb3ea_pkg::PIX_W;
   localparam int CH_W   = bb3ea_pkg::CH_W;
   localparam int NUM_CH = bb3ea_pkg::NUM_CH;
   localparam int SUM_W  = bb3ea_pkg::SUM_W;
   localparam int CNT_W  = bb3ea_pkg::CNT_W;
   localparam int NUM_W  = bb3ea_pkg::NUM_W;
   localparam int DEN_W  = bb3ea_pkg::DEN_W;

   logic [WD_W-1:0]  fw_ff;
   logic [HT_W-1:0]  fh_ff;
   logic             opcode_ff;
   logic [PIX_W-1:0] pixel_ff;
   logic [HT_W-1:0]  in_row_ff, out_row_ff;
   logic [WD_W-1:0]  in_col_ff, out_col_ff;
   logic [1:0]       in_bank_ff, out_bank_ff;

   logic [HT_W:0]    row_nx, near_row;
   logic [WD_W:0]    col_nx, near_col, in_col_nx;
   logic             last_out;

   logic [WD_W:0]    rd_col_x;
   logic             col_ok, col_v_ff;
   logic [COL_AW-1:0] rd_addr;
   logic [PIX_W-1:0] rdata [3];
   logic [2:0]       bank_v;
   logic [1:0]       prev_bank, next_bank;

   logic [SUM_W-1:0] sum_ff [NUM_CH];
   logic [SUM_W-1:0] add_sum [NUM_CH];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] add_cnt;

   logic [NUM_W-1:0] num_ff [NUM_CH];
   logic [DEN_W-1:0] rem_ff [NUM_CH];
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_x [NUM_CH];
   logic             q_bit [NUM_CH];

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_frame_end_ff;

   // readiness of the next output: its lower-right in-frame neighbour has arrived
   always_comb begin
      row_nx    = {1'b0, out_row_ff} + 1'b1;
      near_row  = (row_nx < {1'b0, fh_ff}) ? row_nx : ({1'b0, fh_ff} - 1'b1);
      col_nx    = {1'b0, out_col_ff} + 1'b1;
      near_col  = (col_nx < {1'b0, fw_ff}) ? col_nx : ({1'b0, fw_ff} - 1'b1);
      in_col_nx = {1'b0, in_col_ff} + 1'b1;
      last_out  = ({1'b0, out_row_ff} == ({1'b0, fh_ff} - 1'b1)) &&
                  ({1'b0, out_col_ff} == ({1'b0, fw_ff} - 1'b1));
      status.item_drain = (opcode_ff == bb3ea_pkg::OP_DRAIN);
      status.full       = (in_row_ff >= fh_ff);
      status.out_ready  = ({1'b0, in_row_ff} > near_row) ||
                          (({1'b0, in_row_ff} == near_row) && ({1'b0, in_col_ff} > near_col));
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // rows r-1, r, r+1 live in three banks rotating with the row
   always_comb begin
      prev_bank = (out_bank_ff == 2'd0) ? 2'd2 : (out_bank_ff - 1'b1);
      next_bank = (out_bank_ff == 2'd2) ? 2'd0 : (out_bank_ff + 1'b1);
      for (int b = 0; b < 3; b++) begin
         bank_v[b] = (2'(b) == out_bank_ff) ||
                     ((2'(b) == prev_bank) && (out_row_ff != '0)) ||
                     ((2'(b) == next_bank) && (row_nx < {1'b0, fh_ff}));
      end
      rd_col_x = {1'b0, out_col_ff} + WD_W'(cmd.rd_col) - 1'b1;
      rd_addr  = rd_col_x[COL_AW-1:0];
      case (cmd.rd_col)
         2'd0:    col_ok = (out_col_ff != '0);
         2'd1:    col_ok = 1'b1;
         2'd2:    col_ok = (col_nx < {1'b0, fw_ff});
         default: col_ok = 1'b0;
      endcase
   end

   // row RAMs
   for (genvar b = 0; b < 3; b++) begin : g_bank
      bb3ea_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
         .clock (clock),
         .we    (cmd.write_pixel && (in_bank_ff == 2'(b))),
         .waddr (in_col_ff[COL_AW-1:0]),
         .wdata (pixel_ff),
         .raddr (rd_addr),
         .rdata (rdata[b])
      );
   end

   // column contribution of the three banks
   always_comb begin
      add_cnt = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         add_sum[c] = '0;
         for (int b = 0; b < 3; b++) begin
            if (col_v_ff && bank_v[b]) begin
               add_sum[c] = add_sum[c] + SUM_W'(rdata[b][PIX_W-1-CH_W*c -: CH_W]);
            end
         end
      end
      for (int b = 0; b < 3; b++) begin
         if (col_v_ff && bank_v[b]) begin
            add_cnt = add_cnt + 1'b1;
         end
      end
   end

   // restoring divider step per channel
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         rem_x[c] = {rem_ff[c], num_ff[c][NUM_W-1]};
         q_bit[c] = (rem_x[c] >= {1'b0, den_ff});
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         pixel_ff <= req_pixel;
      end
      if (cmd.rd_issue) begin
         col_v_ff <= col_ok;
      end
      if (cmd.acc_clear) begin
         cnt_ff <= '0;
         for (int c = 0; c < NUM_CH; c++) sum_ff[c] <= '0;
      end else if (cmd.acc_en) begin
         cnt_ff <= cnt_ff + add_cnt;
         for (int c = 0; c < NUM_CH; c++) sum_ff[c] <= sum_ff[c] + add_sum[c];
      end
      if (cmd.div_start) begin
         den_ff <= {cnt_ff, 1'b0};
         for (int c = 0; c < NUM_CH; c++) begin
            num_ff[c] <= NUM_W'({sum_ff[c], 1'b0}) + NUM_W'(cnt_ff);
            rem_ff[c] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int c = 0; c < NUM_CH; c++) begin
            rem_ff[c] <= q_bit[c] ? DEN_W'(rem_x[c] - {1'b0, den_ff}) : DEN_W'(rem_x[c]);
            num_ff[c] <= {num_ff[c][NUM_W-2:0], q_bit[c]};
         end
      end
      if (cmd.load_out) begin
         rsp_frame_end_ff <= last_out;
         for (int c = 0; c < NUM_CH; c++) begin
            rsp_pixel_ff[PIX_W-1-CH_W*c -: CH_W] <= num_ff[c][CH_W-1:0];
         end
      end
   end

   // control registers: sizes, counters, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= WD_W'(FW_RST);
         fh_ff        <= HT_W'(FH_RST);
         opcode_ff    <= bb3ea_pkg::OP_PIXEL;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_bank_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_bank_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.latch_item) begin
            opcode_ff <= req_opcode;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.cfg_write) begin
            if (csr_index == bb3ea_pkg::REG_FRAME_WIDTH) begin
               fw_ff <= WD_W'(bb3ea_pkg::clamp_size(csr_data, MAX_WIDTH));
            end
            if (csr_index == bb3ea_pkg::REG_FRAME_HEIGHT) begin
               fh_ff <= HT_W'(bb3ea_pkg::clamp_size(csr_data, MAX_HEIGHT));
            end
            in_row_ff   <= '0;
            in_col_ff   <= '0;
            in_bank_ff  <= '0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_bank_ff <= '0;
         end
         // advance the input position
         if (cmd.write_pixel) begin
            if (in_col_nx >= {1'b0, fw_ff}) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_bank_ff <= (in_bank_ff == 2'd2) ? 2'd0 : (in_bank_ff + 1'b1);
            end else begin
               in_col_ff <= in_col_nx[WD_W-1:0];
            end
         end
         // transfer a result and advance, or restart at frame end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
            if (last_out) begin
               in_row_ff   <= '0;
               in_col_ff   <= '0;
               in_bank_ff  <= '0;
               out_row_ff  <= '0;
               out_col_ff  <= '0;
               out_bank_ff <= '0;
            end else if (col_nx >= {1'b0, fw_ff}) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + 1'b1;
               out_bank_ff <= next_bank;
            end else begin
               out_col_ff <= col_nx[WD_W-1:0];
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;
endmodule

// ===== design/box_blur_3x3_edge_aware_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit
// Edge-aware 3x3 box blur over a raster RGB stream, rounded half-up.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries pixel items (opcode pixel) in raster order and drain ticks
//  (opcode drain). Each item gives at most one result on rsp_bus, in raster
//  order; frame_end marks the last pixel of the frame. Results lag the input
//  by about one row, so drain ticks flush the tail of a frame. Pixels that
//  arrive after a full frame but before its last result are dropped.
//  csr_bus writes frame_width (index 0) and frame_height (index 1); a write
//  restarts the frame and is taken only while the unit is idle.
//  Flow: one item at a time. An item with a result reads the three row
//  RAMs column by column, then runs the bit-serial rounding divider.
//  A finished result waits in the output register while the next item is
//  taken; a stalled receiver holds the unit only when the next result is due.
//  Reset: sizes 1024 x 1024 (clamped to the maximum), counters cleared, no
//  result pending. Row RAMs are not cleared.
module box_blur_3x3_edge_aware_unit #(
   parameter int MAX_WIDTH  = bb3ea_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3ea_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   bb3ea_req_if.sink   req_bus,
   bb3ea_rsp_if.source rsp_bus,
   bb3ea_csr_if.sink   csr_bus
);
   bb3ea_pkg::cmd_type    cmd;
   bb3ea_pkg::status_type status;

   bb3ea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bb3ea_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_bus.opcode),
      .req_pixel     (req_bus.pixel),
      .csr_index     (csr_bus.reg_index),
      .csr_data      (csr_bus.wdata),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_pixel     (rsp_bus.blurred_pixel),
      .rsp_frame_end (rsp_bus.frame_end)
   );
endmodule

// ===== design/bb3ea_checker.sv =====
// ----------------------------------------------------------------------------
// bb3ea_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bb3ea_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bb3ea_pkg::PIX_W-1:0] rsp_pixel,
   input logic                        rsp_frame_end
);
   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // one item at a time: no transfer in the cycle after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // reset leaves nothing pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");
endmodule

bind box_blur_3x3_edge_aware_unit bb3ea_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pixel     (rsp_bus.blurred_pixel),
   .rsp_frame_end (rsp_bus.frame_end)
);
